// ===== rtl/core/dcuf_pkg.sv =====
// Shared constants and types of the degree-capped union-find edge filter.
`timescale 1ns / 1ps

package dcuf_pkg;

    localparam int VERTEX_W = 6;
    localparam int STATUS_W = 2;
    localparam int DEGREE_W = 2;

    localparam logic [DEGREE_W-1:0] DEG_LIMIT = 2'd2;
    localparam logic [DEGREE_W-1:0] DEG_ONE   = 2'd1;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPT = 2'd0,
        ST_DEGREE = 2'd1,
        ST_SAME   = 2'd2
    } status_t;

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_RDA   = 9'b000000100,
        S_RDB   = 9'b000001000,
        S_WALKA = 9'b000010000,
        S_WALKB = 9'b000100000,
        S_LINKA = 9'b001000000,
        S_LINKB = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

endpackage

// ===== rtl/core/degree_capped_union_find_edge_filter_core.sv =====
// Top level of the degree-capped union-find edge filter with its sequencer and tables.
//
// The input channel (s_valid, s_ready, s_first_vertex, s_second_vertex) takes one candidate
// edge per beat. The result channel (m_valid, m_ready, m_status) returns one status per edge,
// in order: accepted, rejected by the degree limit, or rejected as same component.
// One edge is handled at a time; s_ready is high only while the block is idle, from the
// cycle after the result beat. An out-of-range index yields a degree rejection with no table
// read; otherwise the block reads both degrees (S_RDA, S_RDB) and rejects the edge if either
// has reached the limit, else walks both vertices to their roots (S_WALKA, S_WALKB), one
// link a cycle through the single-read parent table; equal roots give a same-component
// rejection, else the first root is linked under the second and both degrees are raised.
// After reset the block sweeps both tables, one vertex a cycle, over all NUM_VERTICES entries,
// marking every vertex a root with degree zero; s_ready stays low meanwhile.
// While the receiver stalls, the result is held in the output register and no new
// edge is taken until it has been delivered.
`timescale 1ns / 1ps

module degree_capped_union_find_edge_filter_core #(
    parameter int NUM_VERTICES = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [dcuf_pkg::VERTEX_W-1:0]  s_first_vertex,
    input  logic [dcuf_pkg::VERTEX_W-1:0]  s_second_vertex,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [dcuf_pkg::STATUS_W-1:0]  m_status
);

    import dcuf_pkg::*;

    localparam int IDX_W = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
    localparam int CNT_W = $clog2(NUM_VERTICES + 1);
    localparam int EXT_W = IDX_W + VERTEX_W;
    localparam logic [EXT_W-1:0] NV_EXT   = EXT_W'(NUM_VERTICES);
    localparam logic [CNT_W-1:0] NV_CNT   = CNT_W'(NUM_VERTICES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_VERTICES - 1);

    logic [IDX_W:0]          par_mem [NUM_VERTICES];
    logic [DEGREE_W-1:0]     deg_mem [NUM_VERTICES];

    logic [IDX_W:0]          par_rdata_reg;
    logic [DEGREE_W-1:0]     deg_rdata_reg;

    state_t                  state_reg, state_next;
    logic [IDX_W-1:0]        clr_reg, clr_next;
    logic [IDX_W-1:0]        a_reg, a_next;
    logic [IDX_W-1:0]        b_reg, b_next;
    logic [DEGREE_W-1:0]     deg_a_reg, deg_a_next;
    logic [DEGREE_W-1:0]     deg_b_reg, deg_b_next;
    logic [IDX_W-1:0]        cur_reg, cur_next;
    logic [IDX_W-1:0]        ra_reg, ra_next;
    logic [CNT_W-1:0]        steps_reg, steps_next;
    status_t                 status_reg, status_next;
    logic                    m_valid_reg, m_valid_next;

    logic [EXT_W-1:0]        a_ext, b_ext;
    logic                    in_range;
    logic                    in_beat;
    logic                    walk_done;
    logic [IDX_W-1:0]        rd_addr;
    logic                    par_we;
    logic [IDX_W-1:0]        par_waddr;
    logic [IDX_W:0]          par_wdata;
    logic                    deg_we;
    logic [IDX_W-1:0]        deg_waddr;
    logic [DEGREE_W-1:0]     deg_wdata;

    assign a_ext     = {{IDX_W{1'b0}}, s_first_vertex};
    assign b_ext     = {{IDX_W{1'b0}}, s_second_vertex};
    assign in_range  = (a_ext < NV_EXT) && (b_ext < NV_EXT);
    assign s_ready   = (state_reg == S_IDLE);
    assign in_beat   = s_valid && s_ready;
    assign walk_done = par_rdata_reg[IDX_W] || (steps_reg == NV_CNT);
    assign m_valid   = m_valid_reg;
    assign m_status  = status_reg;

    always_ff @(posedge aclk) begin
        if (par_we) begin
            par_mem[par_waddr] <= par_wdata;
        end
        if (deg_we) begin
            deg_mem[deg_waddr] <= deg_wdata;
        end
        par_rdata_reg <= par_mem[rd_addr];
        deg_rdata_reg <= deg_mem[rd_addr];
    end

    always_comb begin
        par_we    = 1'b0;
        par_waddr = ra_reg;
        par_wdata = {1'b0, cur_reg};
        deg_we    = 1'b0;
        deg_waddr = a_reg;
        deg_wdata = deg_a_reg + DEG_ONE;
        rd_addr   = a_reg;
        unique case (state_reg)
            S_CLEAR: begin
                par_we    = 1'b1;
                par_waddr = clr_reg;
                par_wdata = {1'b1, {IDX_W{1'b0}}};
                deg_we    = 1'b1;
                deg_waddr = clr_reg;
                deg_wdata = '0;
            end
            S_IDLE:  rd_addr = a_ext[IDX_W-1:0];
            S_RDA:   rd_addr = b_reg;
            S_RDB:   rd_addr = a_reg;
            S_WALKA: rd_addr = walk_done ? b_reg : par_rdata_reg[IDX_W-1:0];
            S_WALKB: rd_addr = par_rdata_reg[IDX_W-1:0];
            S_LINKA: begin
                par_we = 1'b1;
                deg_we = 1'b1;
            end
            S_LINKB: begin
                deg_we    = 1'b1;
                deg_waddr = b_reg;
                deg_wdata = deg_b_reg + DEG_ONE;
            end
            S_OUT: ;
            default: ;
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        deg_a_next   = deg_a_reg;
        deg_b_next   = deg_b_reg;
        cur_next     = cur_reg;
        ra_next      = ra_reg;
        steps_next   = steps_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg;
        unique case (state_reg)
            S_CLEAR: begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST_IDX) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_beat) begin
                    a_next = a_ext[IDX_W-1:0];
                    b_next = b_ext[IDX_W-1:0];
                    if (in_range) begin
                        state_next = S_RDA;
                    end else begin
                        status_next  = ST_DEGREE;
                        m_valid_next = 1'b1;
                        state_next   = S_OUT;
                    end
                end
            end
            S_RDA: begin
                deg_a_next = deg_rdata_reg;
                state_next = S_RDB;
            end
            S_RDB: begin
                deg_b_next = deg_rdata_reg;
                if ((deg_a_reg >= DEG_LIMIT) || (deg_rdata_reg >= DEG_LIMIT)) begin
                    status_next  = ST_DEGREE;
                    m_valid_next = 1'b1;
                    state_next   = S_OUT;
                end else begin
                    cur_next   = a_reg;
                    steps_next = '0;
                    state_next = S_WALKA;
                end
            end
            S_WALKA: begin
                if (walk_done) begin
                    ra_next    = cur_reg;
                    cur_next   = b_reg;
                    steps_next = '0;
                    state_next = S_WALKB;
                end else begin
                    cur_next   = par_rdata_reg[IDX_W-1:0];
                    steps_next = steps_reg + 1'b1;
                end
            end
            S_WALKB: begin
                if (walk_done) begin
                    if (cur_reg == ra_reg) begin
                        status_next  = ST_SAME;
                        m_valid_next = 1'b1;
                        state_next   = S_OUT;
                    end else begin
                        state_next = S_LINKA;
                    end
                end else begin
                    cur_next   = par_rdata_reg[IDX_W-1:0];
                    steps_next = steps_reg + 1'b1;
                end
            end
            S_LINKA: state_next = S_LINKB;
            S_LINKB: begin
                status_next  = ST_ACCEPT;
                m_valid_next = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        deg_a_reg  <= deg_a_next;
        deg_b_reg  <= deg_b_next;
        cur_reg    <= cur_next;
        ra_reg     <= ra_next;
        steps_reg  <= steps_next;
        status_reg <= status_next;
    end

    // A result beat and a new input beat never overlap.
    assert property (@(posedge aclk) disable iff (!aresetn) m_valid |-> !s_ready)
        else $error("input taken while a result is pending");

    // An index out of range is answered at once with a degree rejection.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_beat && !in_range) |=> (m_valid && (m_status == ST_DEGREE)))
        else $error("out-of-range edge not rejected");

    // A root is only ever linked under a different root.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LINKA) |-> (par_wdata[IDX_W-1:0] != par_waddr))
        else $error("root linked under itself");

    // Degree updates never go beyond the limit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (deg_we && (state_reg != S_CLEAR)) |-> (deg_wdata <= DEG_LIMIT))
        else $error("degree exceeds limit");

endmodule

// ===== verif/degree_capped_union_find_edge_filter_core_tb.sv =====
// Self-checking testbench for the degree-capped union-find edge filter core.
`timescale 1ns / 1ps

module degree_capped_union_find_edge_filter_core_tb;
    import dcuf_pkg::*;

    localparam int NV          = 64;
    localparam int ITEM_TARGET = 1950;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_WAIT  = 200;

    typedef struct packed {
        logic [VERTEX_W-1:0] first;
        logic [VERTEX_W-1:0] second;
    } vertex_pair_t;

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [VERTEX_W-1:0] s_first_vertex = '0;
    logic [VERTEX_W-1:0] s_second_vertex = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [STATUS_W-1:0] m_status;

    vertex_pair_t pending_pairs[$];
    status_t      expected_status[$];
    vertex_pair_t next_pair;
    status_t      oldest_status;
    logic         in_beat = 1'b0;
    int           burst_left = 0;
    int           gap_left = 0;
    int           cycle_count = 0;
    int           error_count = 0;

    logic                vtx_is_root [NV];
    int                  vtx_parent  [NV];
    logic [DEGREE_W-1:0] vtx_degree  [NV];

    degree_capped_union_find_edge_filter_core #(
        .NUM_VERTICES(NV)
    ) u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_first_vertex (s_first_vertex),
        .s_second_vertex(s_second_vertex),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic int walk_to_root(input int v);
        int steps;
        steps = 0;
        while (v < NV && !vtx_is_root[v] && steps < NV) begin
            v = vtx_parent[v];
            steps++;
        end
        return v;
    endfunction

    function automatic status_t predict_edge_status(input logic [VERTEX_W-1:0] a,
                                                    input logic [VERTEX_W-1:0] b);
        int ra;
        int rb;
        if (int'(a) >= NV || int'(b) >= NV) begin
            return ST_DEGREE;
        end
        if (vtx_degree[a] >= DEG_LIMIT || vtx_degree[b] >= DEG_LIMIT) begin
            return ST_DEGREE;
        end
        ra = walk_to_root(int'(a));
        rb = walk_to_root(int'(b));
        if (ra == rb || ra >= NV || rb >= NV) begin
            return ST_SAME;
        end
        vtx_is_root[ra] = 1'b0;
        vtx_parent[ra]  = rb;
        vtx_degree[a]   = vtx_degree[a] + DEG_ONE;
        vtx_degree[b]   = vtx_degree[b] + DEG_ONE;
        return ST_ACCEPT;
    endfunction

    task automatic queue_pair(input int a, input int b);
        vertex_pair_t p;
        p.first  = a[VERTEX_W-1:0];
        p.second = b[VERTEX_W-1:0];
        pending_pairs.push_back(p);
    endtask

    task automatic build_stimulus();
        int perm[NV];
        int path_ends[$];
        int idx;
        int seg_len;
        int j;
        int tmp;
        int a;
        int b;
        int pick;
        // Directed part: self loops at both extremes, reversed and repeated edges,
        // degree saturation, and a pair failing both the degree and the root test.
        queue_pair(0, 0);
        queue_pair(63, 63);
        queue_pair(0, 63);
        queue_pair(63, 0);
        queue_pair(0, 1);
        queue_pair(0, 2);
        queue_pair(2, 0);
        queue_pair(63, 1);
        queue_pair(1, 63);
        queue_pair(0, 1);
        queue_pair(42, 21);
        queue_pair(21, 42);
        queue_pair(42, 42);
        queue_pair(3, 4);
        queue_pair(4, 5);
        queue_pair(5, 3);
        queue_pair(6, 5);
        queue_pair(3, 6);
        queue_pair(7, 3);
        queue_pair(21, 63);
        queue_pair(62, 61);
        // Random paths over a shuffled vertex order, with some noise between the edges.
        for (int i = 0; i < NV; i++) begin
            perm[i] = i;
        end
        for (int i = NV - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
        end
        idx = 0;
        while (idx < NV - 1) begin
            seg_len = $urandom_range(2, 16);
            if (idx + seg_len > NV) begin
                seg_len = NV - idx;
            end
            for (int k = 0; k < seg_len - 1; k++) begin
                if ($urandom_range(0, 1) == 1) begin
                    queue_pair(perm[idx + k], perm[idx + k + 1]);
                end else begin
                    queue_pair(perm[idx + k + 1], perm[idx + k]);
                end
                if ($urandom_range(0, 4) == 0) begin
                    queue_pair($urandom_range(0, NV - 1), $urandom_range(0, NV - 1));
                end
            end
            path_ends.push_back(perm[idx]);
            path_ends.push_back(perm[idx + seg_len - 1]);
            idx += seg_len;
        end
        // Mostly joins and closures between path ends, the rest with one or both ends random.
        while (pending_pairs.size() < ITEM_TARGET) begin
            pick = $urandom_range(0, 9);
            a = path_ends[$urandom_range(0, path_ends.size() - 1)];
            b = path_ends[$urandom_range(0, path_ends.size() - 1)];
            if (pick >= 8) begin
                a = $urandom_range(0, NV - 1);
            end
            if (pick >= 6) begin
                b = $urandom_range(0, NV - 1);
            end
            queue_pair(a, b);
        end
    endtask

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_beat) begin
            if (gap_left > 0) begin
                s_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_pairs.size() != 0) begin
                next_pair = pending_pairs.pop_front();
                s_valid <= 1'b1;
                s_first_vertex <= next_pair.first;
                s_second_vertex <= next_pair.second;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            case ((cycle_count >> 8) % 4)
                0: m_ready <= 1'b1;
                1: m_ready <= $urandom_range(0, 1);
                2: m_ready <= (cycle_count % 8) >= 3;
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        in_beat <= s_valid && s_ready;
        if (aresetn && m_valid && m_ready) begin
            if (expected_status.size() == 0) begin
                $error("status: expected nothing, got %0d", m_status);
                error_count++;
            end else begin
                oldest_status = expected_status.pop_front();
                if (m_status !== oldest_status) begin
                    $error("status: expected %0d, got %0d", oldest_status, m_status);
                    error_count++;
                end
            end
        end
        if (aresetn && s_valid && s_ready) begin
            expected_status.push_back(predict_edge_status(s_first_vertex, s_second_vertex));
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("degree_capped_union_find_edge_filter_core_tb: FAIL");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < NV; i++) begin
            vtx_is_root[i] = 1'b1;
            vtx_parent[i]  = 0;
            vtx_degree[i]  = '0;
        end
        build_stimulus();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        while (pending_pairs.size() != 0 || s_valid || expected_status.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (error_count == 0) begin
            $display("degree_capped_union_find_edge_filter_core_tb: PASS");
        end else begin
            $display("degree_capped_union_find_edge_filter_core_tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== degree_capped_union_find_edge_filter_core.f =====
rtl/core/dcuf_pkg.sv
rtl/core/degree_capped_union_find_edge_filter_core.sv
verif/degree_capped_union_find_edge_filter_core_tb.sv
